// File: rtl/dws_pkg.sv
// shared constants and types for the double-ended queue with search
`default_nettype none
package dws_pkg;

	localparam int DEPTH     = 16;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int OCC_W     = $clog2(DEPTH + 1);
	localparam int DATA_W    = 32;
	localparam int FUNC_W    = 3;
	localparam int POS_W     = 4;
	localparam int STAT_W    = 2;
	localparam int OCC_OUT_W = 5;

	localparam logic [FUNC_W-1:0] OP_PUSH_FRONT = 3'd0;
	localparam logic [FUNC_W-1:0] OP_PUSH_BACK  = 3'd1;
	localparam logic [FUNC_W-1:0] OP_POP_FRONT  = 3'd2;
	localparam logic [FUNC_W-1:0] OP_POP_BACK   = 3'd3;
	localparam logic [FUNC_W-1:0] OP_SEARCH     = 3'd4;

	localparam logic [STAT_W-1:0] STS_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STS_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STS_EMPTY = 2'd2;

	typedef enum logic [2:0] {
		RES_OK    = 3'd0,
		RES_FULL  = 3'd1,
		RES_EMPTY = 3'd2,
		RES_POP   = 3'd3,
		RES_FOUND = 3'd4
	} res_t;

	typedef struct packed {
		logic load;
		logic write_front;
		logic write_back;
		logic rd_start;
		logic rd_next;
		logic retire_front;
		logic retire_back;
		logic finish;
		res_t res;
	} cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              full;
		logic              empty;
		logic              match;
		logic              scan_last;
	} sts_t;

endpackage
`default_nettype wire

// File: rtl/deque_with_search_top.sv
// top level of the double-ended queue with search
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------------
//  command  | start, busy          | func, data_in
//  result   | done (one cycle)     | data_out, found, position, status, occupancy_out
//
// one item at a time; busy is high from acceptance until the result strobe
// push, invalid code or failed push/pop finish in the execute state; a pop finishes in the pop-read state after it
// search reads entries from the front (at most DEPTH), one store read per cycle
// arst_n clears pointers and occupancy; store contents are not cleared
// the receiver cannot stall: a new item may be started while a result is shown
`default_nettype none
module deque_with_search_top
	import dws_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire                      start,
	output logic                     busy,
	input  wire  [FUNC_W-1:0]        func,
	input  wire  signed [DATA_W-1:0] data_in,
	output logic                     done,
	output logic signed [DATA_W-1:0] data_out,
	output logic                     found,
	output logic [POS_W-1:0]         position,
	output logic [STAT_W-1:0]        status,
	output logic [OCC_OUT_W-1:0]     occupancy_out
);

	cmd_t cmd;
	sts_t sts;

	dws_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	dws_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.func          (func),
		.data_in       (data_in),
		.sts           (sts),
		.done          (done),
		.data_out      (data_out),
		.found         (found),
		.position      (position),
		.status        (status),
		.occupancy_out (occupancy_out)
	);

endmodule
`default_nettype wire

// File: rtl/dws_ctrl.sv
// controller state machine sequencing pushes, pops and searches
`default_nettype none
module dws_ctrl
	import dws_pkg::*;
(
	input  wire       clk,
	input  wire       arst_n,
	input  wire       start,
	input  wire sts_t sts,
	output logic      busy,
	output cmd_t      cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_EXEC  = 4'b0010,
		S_POPRD = 4'b0100,
		S_SCAN  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res = RES_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (sts.func) inside
					OP_PUSH_FRONT, OP_PUSH_BACK: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
						if (sts.full) begin
							cmd.res = RES_FULL;
						end else begin
							cmd.write_front = (sts.func == OP_PUSH_FRONT);
							cmd.write_back  = (sts.func == OP_PUSH_BACK);
						end
					end
					OP_POP_FRONT, OP_POP_BACK: begin
						if (sts.empty) begin
							cmd.finish = 1'b1;
							cmd.res    = RES_EMPTY;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_start = 1'b1;
							state_d      = S_POPRD;
						end
					end
					OP_SEARCH: begin
						if (sts.empty) begin
							cmd.finish = 1'b1;
							state_d    = S_IDLE;
						end else begin
							cmd.rd_start = 1'b1;
							state_d      = S_SCAN;
						end
					end
					default: begin
						cmd.finish = 1'b1;
						state_d    = S_IDLE;
					end
				endcase
			end
			S_POPRD: begin
				cmd.retire_front = (sts.func == OP_POP_FRONT);
				cmd.retire_back  = (sts.func == OP_POP_BACK);
				cmd.finish       = 1'b1;
				cmd.res          = RES_POP;
				state_d          = S_IDLE;
			end
			S_SCAN: begin
				if (sts.match) begin
					cmd.finish = 1'b1;
					cmd.res    = RES_FOUND;
					state_d    = S_IDLE;
				end else if (sts.scan_last) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end else begin
					cmd.rd_next = 1'b1;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// File: rtl/dws_dp.sv
// datapath: ring store, front pointer, occupancy, scan index and result registers
`default_nettype none
module dws_dp
	import dws_pkg::*;
(
	input  wire                      clk,
	input  wire                      arst_n,
	input  wire  cmd_t               cmd,
	input  wire  [FUNC_W-1:0]        func,
	input  wire  signed [DATA_W-1:0] data_in,
	output sts_t                     sts,
	output logic                     done,
	output logic signed [DATA_W-1:0] data_out,
	output logic                     found,
	output logic [POS_W-1:0]         position,
	output logic [STAT_W-1:0]        status,
	output logic [OCC_OUT_W-1:0]     occupancy_out
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;
	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [IDX_W-1:0]  front_q;
	logic [OCC_W-1:0]  occ_q;
	logic [IDX_W-1:0]  idx_q;
	logic              done_q;
	logic [DATA_W-1:0] data_out_q;
	logic              found_q;
	logic [POS_W-1:0]  position_q;
	logic [STAT_W-1:0] status_q;

	logic [IDX_W-1:0]  occ_lo;
	logic [IDX_W-1:0]  front_dec;
	logic [IDX_W-1:0]  wr_addr;
	logic [IDX_W-1:0]  rd_addr;
	logic              wr_en;
	logic              rd_en;

	assign occ_lo    = occ_q[IDX_W-1:0];
	assign front_dec = front_q - IDX_W'(1);
	assign wr_en     = cmd.write_front | cmd.write_back;
	assign wr_addr   = cmd.write_front ? front_dec : (front_q + occ_lo);
	assign rd_en     = cmd.rd_start | cmd.rd_next;

	always_comb begin
		if (cmd.rd_next) begin
			rd_addr = front_q + idx_q + IDX_W'(1);
		end else if (func_q == OP_POP_BACK) begin
			rd_addr = front_q + occ_lo - IDX_W'(1);
		end else begin
			rd_addr = front_q;
		end
	end

	// ring store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= value_q;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q  <= func;
			value_q <= data_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q   <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.write_front) begin
				front_q <= front_dec;
			end else if (cmd.retire_front) begin
				front_q <= front_q + IDX_W'(1);
			end
			if (wr_en) begin
				occ_q <= occ_q + OCC_W'(1);
			end else if (cmd.retire_front | cmd.retire_back) begin
				occ_q <= occ_q - OCC_W'(1);
			end
			if (cmd.rd_start) begin
				idx_q <= '0;
			end else if (cmd.rd_next) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.finish;
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			data_out_q <= (cmd.res == RES_POP) ? rd_data_q : '0;
			found_q    <= (cmd.res == RES_FOUND);
			position_q <= (cmd.res == RES_FOUND) ? POS_W'(idx_q) : '0;
			case (cmd.res)
				RES_FULL:  status_q <= STS_FULL;
				RES_EMPTY: status_q <= STS_EMPTY;
				default:   status_q <= STS_OK;
			endcase
		end
	end

	assign sts.func      = func_q;
	assign sts.full      = (occ_q == OCC_W'(DEPTH));
	assign sts.empty     = (occ_q == '0);
	assign sts.match     = (rd_data_q == value_q);
	assign sts.scan_last = ((OCC_W'(idx_q) + OCC_W'(1)) == occ_q);

	assign done          = done_q;
	assign data_out      = data_out_q;
	assign found         = found_q;
	assign position      = position_q;
	assign status        = status_q;
	assign occupancy_out = OCC_OUT_W'(occ_q);

endmodule
`default_nettype wire
